// File: sv/bf_pkg.sv
// ----------------------------------------------------------------------------
// bf_pkg: shared constants and types for the 64-bit block cipher
// Table geometry, command codes, stream packing and the round function.
// ----------------------------------------------------------------------------
`default_nettype none

package bf_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_W      = 64;
    localparam int FUNC_W       = 2;
    localparam int INDEX_W      = 10;
    localparam int P_DEPTH      = 18;
    localparam int P_IDX_W      = $clog2(P_DEPTH);
    localparam int NUM_BOXES    = 4;
    localparam int SBOX_ENTRIES = 256;
    localparam int SBOX_ADDR_W  = $clog2(SBOX_ENTRIES);
    localparam int DEF_ROUNDS   = 16;

    // Input tdata packing, lowest bit first: table index, table word, plaintext.
    localparam int IDX_LSB      = 0;
    localparam int WORD_LSB     = IDX_LSB + INDEX_W;
    localparam int PLAIN_LSB    = WORD_LSB + WORD_W;
    localparam int S_DATA_BITS  = PLAIN_LSB + BLOCK_W;
    localparam int S_TDATA_W    = ((S_DATA_BITS + 7) / 8) * 8;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [FUNC_W-1:0]  func_t;

    localparam func_t FUNC_WRITE_P = 2'd0;
    localparam func_t FUNC_WRITE_S = 2'd1;
    localparam func_t FUNC_ENCRYPT = 2'd2;

    // Round function from the four S-box words already looked up.
    function automatic word_t round_f(input word_t s0, input word_t s1,
                                      input word_t s2, input word_t s3);
        word_t sum01;
        sum01 = s0 + s1;
        return (sum01 ^ s2) + s3;
    endfunction

endpackage

`default_nettype wire

// File: sv/blowfish_block_encrypt.sv
// ----------------------------------------------------------------------------
// blowfish_block_encrypt: 64-bit block cipher engine with host-loaded tables
// Feistel rounds run one per clock over four S-box RAMs and a P-word file.
// ----------------------------------------------------------------------------
// The host first loads the 18-word P-array and the four 256-word S-boxes with
// table-write transfers on the input stream (tuser selects the operation), one
// transfer per cycle, and then sends encrypt transfers carrying a 64-bit
// plaintext whose left half sits in the upper 32 bits. A table write gives no
// result; a P write to an index of 18 or above and an unused operation code
// are dropped. An encrypt transfer then occupies the engine for ROUNDS Feistel
// rounds, one per cycle, so a new encrypt transfer is taken only once the last
// round of the previous block is done. The round loop sets that pace: each
// round needs one read from each of the four S-box RAMs, whose registered
// outputs feed the round function, whose result in turn forms the next read
// addresses. The input is not ready while rounds are in progress. The
// ciphertext is held in an output register, so a new block can be taken while
// the previous result waits; if that result has still not been transferred
// when the last round finishes, the engine holds in its last round until it
// has. Tables come up undefined after reset and must be loaded before the
// first encrypt; no clearing pass is made.
// ----------------------------------------------------------------------------
`default_nettype none

module blowfish_block_encrypt
    import bf_pkg::*;
#(
    parameter int ROUNDS = DEF_ROUNDS
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    // Input stream.
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // tdata, lowest bit up: table_index[9:0], table_word[41:10],
    // plain_block[105:42], zero padding[111:106].
    input  wire  [S_TDATA_W-1:0] s_tdata,
    // tuser: func[1:0] (write P word, write S-box word, encrypt block).
    input  wire  [FUNC_W-1:0]    s_tuser,
    // Result stream.
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // tdata, lowest bit up: cipher_block[63:0].
    output logic [BLOCK_W-1:0]   m_tdata
);

    localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [RND_W-1:0]   LAST_ROUND = RND_W'(ROUNDS - 1);
    localparam logic [P_IDX_W-1:0] P_FINAL_L  = P_IDX_W'(ROUNDS + 1);

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [RND_W-1:0] round_reg, round_next;
    word_t            left_reg, left_next;
    word_t            right_reg, right_next;
    logic             out_valid_reg, out_valid_next;
    block_t           out_data_reg, out_data_next;

    word_t            p_words [P_DEPTH];
    word_t            s_rd_reg [NUM_BOXES];

    // Input field unpacking.
    logic [INDEX_W-1:0] in_index;
    word_t              in_word;
    block_t             in_plain;
    logic               in_xfer;

    assign in_index = s_tdata[IDX_LSB +: INDEX_W];
    assign in_word  = s_tdata[WORD_LSB +: WORD_W];
    assign in_plain = s_tdata[PLAIN_LSB +: BLOCK_W];
    assign in_xfer  = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // P-array: small register file, written by host transfers only.
    always_ff @(posedge aclk) begin
        if (in_xfer && s_tuser == FUNC_WRITE_P && in_index < INDEX_W'(P_DEPTH)) begin
            p_words[in_index[P_IDX_W-1:0]] <= in_word;
        end
    end

    // Round datapath. The word after this round is the next left half, which
    // already carries the following P word, ready to address the S-boxes.
    word_t              f_val;
    word_t              round_out;
    logic [P_IDX_W-1:0] p_idx;
    logic               last_round;
    logic               out_free;

    assign f_val      = round_f(s_rd_reg[0], s_rd_reg[1], s_rd_reg[2], s_rd_reg[3]);
    assign p_idx      = P_IDX_W'(round_reg) + P_IDX_W'(1);
    assign round_out  = right_reg ^ f_val ^ p_words[p_idx];
    assign last_round = (round_reg == LAST_ROUND);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_tuser == FUNC_ENCRYPT) begin
                    left_next  = in_plain[BLOCK_W-1:WORD_W] ^ p_words[0];
                    right_next = in_plain[WORD_W-1:0];
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!last_round) begin
                    left_next  = round_out;
                    right_next = left_reg;
                    round_next = round_reg + RND_W'(1);
                end else if (out_free) begin
                    // Final swap and whitening folded into the last round.
                    out_data_next  = {left_reg ^ p_words[P_FINAL_L], round_out};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // S-box RAMs, one per box so that all four lookups of a round happen in the
    // same cycle. Reads follow the next left half, so the registered data lines
    // up with left_reg in the following cycle.
    genvar b;
    generate
        for (b = 0; b < NUM_BOXES; b++) begin : g_sbox
            word_t sbox_mem [SBOX_ENTRIES];

            always_ff @(posedge aclk) begin
                if (in_xfer && s_tuser == FUNC_WRITE_S &&
                    in_index[INDEX_W-1:SBOX_ADDR_W] == (INDEX_W - SBOX_ADDR_W)'(b)) begin
                    sbox_mem[in_index[SBOX_ADDR_W-1:0]] <= in_word;
                end
                s_rd_reg[b] <= sbox_mem[left_next[SBOX_ADDR_W*(NUM_BOXES-1-b) +: SBOX_ADDR_W]];
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
        left_reg     <= left_next;
        right_reg    <= right_next;
        out_data_reg <= out_data_next;
    end

    // An encrypt transfer starts the rounds from the first one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == FUNC_ENCRYPT)
            |=> (state_reg == ST_RUN && round_reg == '0))
        else $error("encrypt transfer did not start the round sequence");

    // Table writes and unused codes leave the engine idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != FUNC_ENCRYPT) |=> (state_reg == ST_IDLE))
        else $error("non-encrypt transfer left the idle state");

    // Rounds advance by one each cycle until the last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && round_reg != LAST_ROUND)
            |=> (state_reg == ST_RUN && round_reg == $past(round_reg) + RND_W'(1)))
        else $error("round counter did not advance");

    // A new result appears only as the last round completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_RUN && round_reg == LAST_ROUND))
        else $error("result raised outside the last round");

endmodule

`default_nettype wire
